// ----- rtl/handle_pool_tracker_core_defines.svh -----
// Assertion macros shared by the handle pool tracker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HANDLE_POOL_TRACKER_CORE_DEFINES_SVH
`define HANDLE_POOL_TRACKER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define HPT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("handle pool tracker check failed");

// An implication checked in the same cycle.
`define HPT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("handle pool tracker check failed");

`endif

// ----- rtl/hpt_pkg.sv -----
package hpt_pkg;

  // Pool size and the widths that follow from it.
  localparam int POOL_ENTRIES = 64;
  localparam int IDX_W        = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);
  localparam int HANDLE_W     = 64;
  localparam int USE_W        = 7;

  localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_ENTRIES - 1);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_DONE
  } state_t;

endpackage

// ----- rtl/hpt_ram.sv -----
module hpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/handle_pool_tracker_core.sv -----
// Channel    Direction  Handshake            Word carried
// request    in         req_valid/req_stall  opcode, handle
// response   out        rsp_valid/rsp_stall  status, entries_in_use
//
// An allocate is accepted from the idle state, scans the valid bits for the
// lowest free slot and posts its result from the done state. A free reads the
// handle store entry by entry, since it is a RAM with a registered read port
// that feeds the one shared 64-bit comparator, and posts its result likewise.
// Null handles, a full pool on allocate and an empty pool on free are
// answered without a scan. Reset clears the valid bits and the count at once.
// A stalled response holds the block in its result state; the request side
// is stalled whenever a request is being worked on.
`include "handle_pool_tracker_core_defines.svh"

module handle_pool_tracker_core
  import hpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                opcode,
  input  logic [HANDLE_W-1:0] handle,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [1:0]          status,
  output logic [USE_W-1:0]    entries_in_use
);

  // Sequencer state and the request being worked on.
  state_t              state;
  state_t              state_next;
  opcode_t             op_q;
  logic [HANDLE_W-1:0] handle_q;

  // Scan counter: the entry under test for allocate, the next read for free.
  logic [CNT_W-1:0]    scan_cnt;
  logic [CNT_W-1:0]    scan_cnt_next;
  logic [IDX_W-1:0]    scan_idx;

  // Compare stage, fed from the RAM read address of the cycle before.
  logic                cmp_vld;
  logic                cmp_vld_next;
  logic [IDX_W-1:0]    cmp_idx;

  // Pool occupancy.
  logic [POOL_ENTRIES-1:0] valid;
  logic [POOL_ENTRIES-1:0] valid_next;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;

  status_t             res;
  status_t             res_next;
  logic                rsp_load;

  // Handle store port signals.
  logic                ram_we;
  logic                ram_re;
  logic [HANDLE_W-1:0] ram_rdata;
  logic                hit;

  assign req_stall = (state != S_IDLE);
  assign scan_idx  = scan_cnt[IDX_W-1:0];

  // The single shared comparator: the entry read last cycle against the
  // request's handle. Entries that were never written are masked by valid.
  assign hit = cmp_vld && valid[cmp_idx] && (ram_rdata == handle_q);

  hpt_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (POOL_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scan_idx),
    .wdata (handle_q),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    cmp_vld_next  = 1'b0;
    valid_next    = valid;
    count_next    = count;
    res_next      = res;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    rsp_load      = 1'b0;

    unique case (state)
      S_IDLE: begin
        scan_cnt_next = '0;
        if (req_valid) begin
          if (opcode_t'(opcode) == OP_ALLOC) begin
            if (handle == '0) begin
              res_next   = ST_NULL;
              state_next = S_DONE;
            end else if (count == POOL_CNT) begin
              res_next   = ST_FULL;
              state_next = S_DONE;
            end else begin
              state_next = S_ALLOC;
            end
          end else begin
            // A valid entry never holds zero, so a null free cannot match.
            if ((handle == '0) || (count == '0)) begin
              res_next   = ST_MISSING;
              state_next = S_DONE;
            end else begin
              state_next = S_FREE;
            end
          end
        end
      end

      S_ALLOC: begin
        // The pool is known not to be full, so a free slot is always found.
        if (!valid[scan_idx]) begin
          ram_we               = 1'b1;
          valid_next[scan_idx] = 1'b1;
          count_next           = count + CNT_W'(1);
          res_next             = ST_OK;
          state_next           = S_DONE;
        end else begin
          scan_cnt_next = scan_cnt + CNT_W'(1);
        end
      end

      S_FREE: begin
        if (hit) begin
          valid_next[cmp_idx] = 1'b0;
          count_next          = count - CNT_W'(1);
          res_next            = ST_OK;
          state_next          = S_DONE;
        end else if (cmp_vld && (cmp_idx == LAST_IDX)) begin
          res_next   = ST_MISSING;
          state_next = S_DONE;
        end else if (scan_cnt != POOL_CNT) begin
          ram_re        = 1'b1;
          cmp_vld_next  = 1'b1;
          scan_cnt_next = scan_cnt + CNT_W'(1);
        end
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_vld   <= 1'b0;
      valid     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= cmp_vld_next;
      valid   <= valid_next;
      count   <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_cnt <= scan_cnt_next;
    cmp_idx  <= scan_idx;
    res      <= res_next;
    if (req_valid && !req_stall) begin
      op_q     <= opcode_t'(opcode);
      handle_q <= handle;
    end
    if (rsp_load) begin
      status         <= res;
      entries_in_use <= USE_W'(count);
    end
  end

  // The count always agrees with the valid bits and stays within the pool.
  `HPT_ASSERT_ALWAYS(a_count_matches_valid, $countones(valid) == count)
  `HPT_ASSERT_ALWAYS(a_count_in_range, count <= POOL_CNT)
  // An allocate scan only runs when a free slot exists.
  `HPT_ASSERT_IMP(a_alloc_has_room, state == S_ALLOC, (count != POOL_CNT) && (op_q == OP_ALLOC))
  // The compare stage is only ever live during a free scan.
  `HPT_ASSERT_IMP(a_cmp_only_in_free, cmp_vld, (state == S_FREE) && (op_q == OP_FREE))

endmodule

// ----- bench/tb_handle_pool_tracker_core.sv -----
module tb_handle_pool_tracker_core;
  import hpt_pkg::*;

  // One response word as the pool should report it: the status code and the
  // number of occupied entries, truncated to the width of the port.
  typedef struct packed {
    status_t          st;
    logic [USE_W-1:0] used;
  } pool_reply_t;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                req_valid      = 1'b0;
  logic                req_stall;
  logic                opcode         = OP_ALLOC;
  logic [HANDLE_W-1:0] handle         = '0;
  logic                rsp_valid;
  logic                rsp_stall      = 1'b0;
  logic [1:0]          status;
  logic [USE_W-1:0]    entries_in_use;

  // The bench keeps its own picture of the pool: which entries are occupied,
  // what each holds and how many are in use.
  logic [HANDLE_W-1:0] pool_handle [POOL_ENTRIES];
  bit                  pool_busy   [POOL_ENTRIES];
  int unsigned         pool_used;

  // Response words still owed by the block, oldest first.
  pool_reply_t         pending_replies [$];
  int unsigned         error_count;

  // While set, neither side inserts idle cycles, giving a stretch of
  // back-to-back traffic.
  bit                  steady_flow;

  handle_pool_tracker_core dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .opcode         (opcode),
    .handle         (handle),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .entries_in_use (entries_in_use)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the bench's copy of the pool and returns the status
  // that the block should give. An allocate fills the lowest free entry; a free
  // releases the lowest occupied entry holding the same handle. A null handle
  // is refused on allocate before the pool is looked at, and on free it can
  // never match, since an occupied entry never holds zero.
  function automatic status_t apply_to_pool(opcode_t op, logic [HANDLE_W-1:0] h);
    if (op == OP_ALLOC) begin
      if (h == '0) return ST_NULL;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        if (!pool_busy[i]) begin
          pool_handle[i] = h;
          pool_busy[i]   = 1'b1;
          pool_used++;
          return ST_OK;
        end
      end
      return ST_FULL;
    end
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      if (pool_busy[i] && pool_handle[i] == h) begin
        pool_busy[i] = 1'b0;
        pool_used--;
        return ST_OK;
      end
    end
    return ST_MISSING;
  endfunction

  // A handle of a random kind. Small values are drawn often so that the same
  // handle is recorded more than once; the all-ones value and single set bits
  // cover the ends of the field.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 15) return HANDLE_W'($urandom_range(6, 1));
    if (kind < 20) return '1;
    if (kind < 25) return HANDLE_W'(1) << $urandom_range(HANDLE_W - 1);
    return {$urandom, $urandom};
  endfunction

  // A handle that is currently held somewhere in the pool. Only called while
  // at least one entry is occupied.
  function automatic logic [HANDLE_W-1:0] pick_stored_handle();
    int unsigned idx;
    do idx = $urandom_range(POOL_ENTRIES - 1); while (!pool_busy[idx]);
    return pool_handle[idx];
  endfunction

  // Offers one request word and returns at the clock edge at which it is
  // taken. The expected response is worked out at that edge, so the bench's
  // pool follows the block in the order in which requests are accepted.
  // Valid stays high on return: the caller either offers the next word at once
  // or lowers valid through wait_for_replies.
  task automatic send_request(opcode_t op, logic [HANDLE_W-1:0] h);
    pool_reply_t reply;
    if (!steady_flow && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    req_valid <= 1'b1;
    opcode    <= op;
    handle    <= h;
    do @(posedge clk); while (req_stall !== 1'b0);
    reply.st   = apply_to_pool(op, h);
    reply.used = USE_W'(pool_used);
    pending_replies.push_back(reply);
  endtask

  // Withdraws the request side and holds off until every response owed has
  // been received, so that the block is seen to drain completely.
  task automatic wait_for_replies();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // One request from a mix of well-formed and awkward traffic. Allocates
  // mostly carry fresh handles, with the odd null one; most frees name a
  // handle that is really held, and the rest name zero, a random handle, or a
  // held handle with one bit flipped; zero always comes back not found.
  task automatic send_mixed_request(int unsigned alloc_pct);
    logic [HANDLE_W-1:0] h;
    if ($urandom_range(99) < alloc_pct) begin
      h = ($urandom_range(99) < 4) ? '0 : pick_handle();
      send_request(OP_ALLOC, h);
    end else if (pool_used != 0 && $urandom_range(99) < 75) begin
      send_request(OP_FREE, pick_stored_handle());
    end else begin
      case ($urandom_range(2))
        0: h = '0;
        1: h = pick_handle();
        default: begin
          if (pool_used != 0) begin
            h = pick_stored_handle() ^ (HANDLE_W'(1) << $urandom_range(HANDLE_W - 1));
          end else begin
            h = pick_handle();
          end
        end
      endcase
      send_request(OP_FREE, h);
    end
  endtask

  // Hand-picked requests: null handles on both operations, frees on an empty
  // pool, the extreme handle values, a handle recorded twice and freed three
  // times, and near misses that differ from a held handle in one bit.
  task automatic test_directed_cases();
    send_request(OP_FREE,  '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE,  64'h1);
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, 64'h1);
    send_request(OP_ALLOC, 64'h8000_0000_0000_0000);
    send_request(OP_FREE,  64'hFFFF_FFFF_FFFF_FFFE);
    send_request(OP_FREE,  '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, 64'h1);
    send_request(OP_FREE,  64'h1);
    send_request(OP_FREE,  64'h1);
    send_request(OP_FREE,  64'h1);
    send_request(OP_ALLOC, 64'h5555_5555_5555_5555);
    send_request(OP_FREE,  64'hAAAA_AAAA_AAAA_AAAA);
    send_request(OP_FREE,  64'h5555_5555_5555_5555);
    send_request(OP_FREE,  '1);
    send_request(OP_FREE,  64'h8000_0000_0000_0000);
    send_request(OP_FREE,  64'h8000_0000_0000_0000);
    wait_for_replies();
  endtask

  // Fills the pool to the last entry, knocks on it while full (a null handle
  // must still be reported as null rather than full), lets the block drain,
  // then empties it again in random order.
  task automatic test_fill_and_overflow();
    repeat (2) begin
      while (pool_used < POOL_ENTRIES) send_request(OP_ALLOC, pick_handle());
      send_request(OP_ALLOC, pick_handle());
      send_request(OP_ALLOC, '0);
      send_request(OP_ALLOC, '1);
      send_request(OP_FREE,  '0);
      wait_for_replies();
      while (pool_used != 0) send_request(OP_FREE, pick_stored_handle());
      send_request(OP_FREE, pick_handle());
    end
    wait_for_replies();
  endtask

  // Mixed traffic in blocks whose balance of allocates and frees changes, so
  // the pool swings between nearly empty and full.
  task automatic test_random_traffic();
    int unsigned alloc_pct;
    repeat (12) begin
      case ($urandom_range(2))
        0:       alloc_pct = 85;
        1:       alloc_pct = 55;
        default: alloc_pct = 25;
      endcase
      repeat (100) send_mixed_request(alloc_pct);
    end
    wait_for_replies();
  endtask

  // A long run with neither side idling, so requests arrive the moment the
  // block can take them and responses leave the moment they are ready.
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (300) send_mixed_request(60);
    wait_for_replies();
    steady_flow = 1'b0;
  endtask

  // Response side: each word taken is compared with the oldest expectation,
  // and outside steady flow the stall for the next edge is chosen at random.
  always @(posedge clk) begin : reply_check
    pool_reply_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: response word with none expected: status %0d entries_in_use %0d",
                 $time, status, entries_in_use);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.st) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.st, status);
          error_count++;
        end
        if (entries_in_use !== want.used) begin
          $display("%0t: entries_in_use mismatch: expected %0d, actual %0d",
                   $time, want.used, entries_in_use);
          error_count++;
        end
      end
    end
    rsp_stall <= !steady_flow && ($urandom_range(99) < 30);
  end

  // Reset once, run the tests in turn, then leave time for any stray word
  // from the block to show itself before judging the run.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_fill_and_overflow();
    test_random_traffic();
    test_back_to_back();
    repeat (2 * POOL_ENTRIES + 8) @(posedge clk);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("handle_pool_tracker_core test passed");
    end else begin
      $display("handle_pool_tracker_core test failed");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #10000000;
    $display("handle_pool_tracker_core test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/hpt_pkg.sv
rtl/hpt_ram.sv
rtl/handle_pool_tracker_core.sv
bench/tb_handle_pool_tracker_core.sv
